/* rtl/lsbd_pkg.sv */
// Shared types and constants for the two-bit LSB message deframer.
`default_nettype none
package lsbd_pkg;

   localparam int unsigned NAME_BYTES_DEFAULT = 32;
   localparam int unsigned PIX_W    = 8;
   localparam int unsigned IMG_W    = 26;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned AVAIL_W  = IMG_W - 2;
   localparam int unsigned CNT_W    = AVAIL_W;
   localparam int unsigned FIELD_W  = 4;
   localparam int unsigned LEN_HDR_BYTES = 4;
   localparam int unsigned BYTE_PIXELS   = 4;

   typedef enum logic [1:0] {
      KIND_NAME    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_LEN     = 4'b0001,
      PH_NAME    = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_IDLE    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             start_req;
   } item_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [LEN_W-1:0] message_length;
      logic             last;
   } result_type;

endpackage
`default_nettype wire

/* rtl/lsb2_steg_message_deframer_top.sv */
// Top level of the two-bit LSB message deframer.
//
//   Channel   Direction  Handshake             Beat contents
//   req_      in         req_valid/req_stall   pixel_value, start_req
//   rsp_      out        rsp_valid/rsp_stall   kind, data, message_length, last
//   csr_      in         csr_write_enable      image_pixels
//
// One pixel beat is taken per cycle while no stall holds the stream. A beat is held in
// the input register and decoded there, and any result is loaded into the output
// register, which drives rsp_valid. The output register is the only thing that
// can hold the stream: while it is full and stalled, the input register stalls.
// Reset is synchronous and returns the parser to the length header with the
// available space at zero.
`default_nettype none
module lsb2_steg_message_deframer_top #(
   parameter int unsigned NAME_BYTES = lsbd_pkg::NAME_BYTES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [lsbd_pkg::PIX_W-1:0] req_pixel_value,
   input  wire logic                       req_start_req,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_data,
   output logic [lsbd_pkg::LEN_W-1:0]      rsp_message_length,
   output logic                            rsp_last,
   input  wire logic                       csr_write_enable,
   input  wire logic [lsbd_pkg::IMG_W-1:0] csr_image_pixels
);
   import lsbd_pkg::*;

   item_type   req_item, item;
   logic       item_valid, out_free, fire, res_valid;
   result_type res, rsp_res;

   assign req_item.pixel_value = req_pixel_value;
   assign req_item.start_req   = req_start_req;

   // A held pixel is decoded only when its result, if any, has a free slot.
   assign fire = item_valid && out_free;

   lsbd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance_ok (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   lsbd_core #(
      .NAME_BYTES (NAME_BYTES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_image_pixels (csr_image_pixels),
      .fire             (fire),
      .item             (item),
      .res_valid        (res_valid),
      .res              (res)
   );

   lsbd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_kind           = rsp_res.kind;
   assign rsp_data           = rsp_res.data;
   assign rsp_message_length = rsp_res.message_length;
   assign rsp_last           = rsp_res.last;

endmodule
`default_nettype wire

/* rtl/lsbd_in_reg.sv */
// Input register stage that holds one accepted pixel beat.
`default_nettype none
module lsbd_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lsbd_pkg::item_type req_item,
   input  wire logic              advance_ok,
   output logic                   item_valid,
   output lsbd_pkg::item_type     item
);
   import lsbd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_stall = valid_ff && !advance_ok;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance_ok) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

/* rtl/lsbd_core.sv */
// Header parser and byte assembler: per-pixel state update and result decode.
`default_nettype none
module lsbd_core #(
   parameter int unsigned NAME_BYTES = lsbd_pkg::NAME_BYTES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [lsbd_pkg::IMG_W-1:0] csr_image_pixels,
   input  wire logic                     fire,
   input  wire lsbd_pkg::item_type       item,
   output logic                          res_valid,
   output lsbd_pkg::result_type          res
);
   import lsbd_pkg::*;

   localparam logic [AVAIL_W-1:0] HDR_BYTES = AVAIL_W'(LEN_HDR_BYTES + NAME_BYTES);
   localparam logic [CNT_W-1:0]   NAME_CNT  = CNT_W'(NAME_BYTES);

   phase_type           phase_ff, phase_in;
   logic [LEN_W-1:0]    shift_ff, shift_in;
   logic [FIELD_W-1:0]  pif_ff, pif_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [AVAIL_W-1:0]  avail_ff, avail_in;

   phase_type           ph_b;
   logic [LEN_W-1:0]    sh_b, len_b, sh_new;
   logic [FIELD_W-1:0]  pif_b, pif_new;
   logic [CNT_W-1:0]    cnt_b, cnt_inc;
   logic [AVAIL_W-1:0]  quarter;

   // Space left for payload bytes, saturating at zero; recomputed on each write.
   always_comb begin
      quarter  = csr_image_pixels[IMG_W-1:2];
      avail_in = avail_ff;
      if (csr_write_enable) begin
         avail_in = (quarter > HDR_BYTES) ? (quarter - HDR_BYTES) : '0;
      end
   end

   always_comb begin
      // A start flag restarts parsing with this pixel as the first header pixel.
      ph_b  = item.start_req ? PH_LEN : phase_ff;
      sh_b  = item.start_req ? '0 : shift_ff;
      pif_b = item.start_req ? '0 : pif_ff;
      cnt_b = item.start_req ? '0 : cnt_ff;
      len_b = item.start_req ? '0 : len_ff;

      sh_new  = {sh_b[LEN_W-3:0], item.pixel_value[1:0]};
      pif_new = pif_b + FIELD_W'(1);
      cnt_inc = cnt_b + CNT_W'(1);

      phase_in  = ph_b;
      shift_in  = sh_b;
      pif_in    = pif_b;
      cnt_in    = cnt_b;
      len_in    = len_b;
      res_valid = 1'b0;
      res.kind           = KIND_NAME;
      res.data           = sh_new[7:0];
      res.message_length = len_b;
      res.last           = 1'b0;

      case (ph_b)
         PH_LEN: begin
            shift_in = sh_new;
            pif_in   = pif_new;
            // Sixteen pixels wrap the field counter back to zero.
            if (pif_new == '0) begin
               len_in   = sh_new;
               shift_in = '0;
               cnt_in   = '0;
               if (sh_new > LEN_W'(avail_ff)) begin
                  phase_in           = PH_IDLE;
                  res_valid          = 1'b1;
                  res.kind           = KIND_ERROR;
                  res.data           = '0;
                  res.message_length = sh_new;
                  res.last           = 1'b1;
               end else begin
                  phase_in = PH_NAME;
               end
            end
         end
         PH_NAME, PH_PAYLOAD: begin
            shift_in = sh_new;
            pif_in   = pif_new;
            if (pif_new >= FIELD_W'(BYTE_PIXELS)) begin
               pif_in    = '0;
               shift_in  = '0;
               cnt_in    = cnt_inc;
               res_valid = 1'b1;
               if (ph_b == PH_NAME) begin
                  res.kind = KIND_NAME;
                  if (cnt_inc >= NAME_CNT) begin
                     cnt_in = '0;
                     if (len_b == '0) begin
                        res.last = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end else begin
                  res.kind = KIND_PAYLOAD;
                  if (LEN_W'(cnt_inc) >= len_b) begin
                     res.last = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         shift_ff <= '0;
         pif_ff   <= '0;
         cnt_ff   <= '0;
         len_ff   <= '0;
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
         if (fire) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            pif_ff   <= pif_in;
            cnt_ff   <= cnt_in;
            len_ff   <= len_in;
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/lsbd_out_reg.sv */
// Result register that holds one beat until the consumer takes it.
`default_nettype none
module lsbd_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire lsbd_pkg::result_type res,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lsbd_pkg::result_type      rsp_res
);
   import lsbd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule
`default_nettype wire
